### sv/tetd_pkg.sv
// tetd_pkg: format codes and classification types for the element widener
// no dependencies
package tetd_pkg;
  localparam logic [1:0] FMT_DOUBLE = 2'd0;
  localparam logic [1:0] FMT_SINGLE = 2'd1;
  localparam logic [1:0] FMT_HALF   = 2'd2;
  localparam logic [1:0] FMT_BF16   = 2'd3;

  localparam logic [1:0] CLS_NORM = 2'd0;
  localparam logic [1:0] CLS_ZERO = 2'd1;
  localparam logic [1:0] CLS_SUB  = 2'd2;
  localparam logic [1:0] CLS_SPEC = 2'd3;

  // unpacked element after stage one
  typedef struct packed {
    logic        pass;     // double pass-through
    logic [63:0] raw;
    logic        sign;
    logic        is_half;
    logic [1:0]  cls;
    logic [7:0]  ex;       // source exponent (half zero-extended)
    logic [22:0] fr;       // fraction, left aligned to 23 bits
  } unpk_t;

  // after leading-one search
  typedef struct packed {
    logic        pass;
    logic [63:0] raw;
    logic        sign;
    logic        is_half;
    logic [1:0]  cls;
    logic [7:0]  ex;
    logic [22:0] fr;
    logic [4:0]  lz;       // leading zeros of fr
  } lzc_t;
endpackage

### sv/tensor_element_to_double_top.sv
// tensor_element_to_double_top: widens a raw tensor element to binary64
// depends on tetd_pkg, tetd_unpack, tetd_lzc, tetd_pack
//
// channel   | ports                                   | handshake
// config    | element_format_we_i, element_format_i   | written on any edge with we high
// input     | start_i, raw_bits_i, busy_o             | taken when start high, busy low
// result    | done_o, value_bits_o                    | one-cycle strobe, no back-pressure
//
// three register stages: unpack, leading-zero count, normalise and pack
// one word per clock
// busy is always low: the receiver cannot stall so nothing backs up
// reset clears the stage valid bits and selects double
module tensor_element_to_double_top import tetd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        element_format_we_i,
  input  logic [1:0]  element_format_i,
  input  logic        start_i,
  input  logic [63:0] raw_bits_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] value_bits_o
);
  logic [1:0] fmt_q;
  logic       v1, v2;
  unpk_t      d1;
  lzc_t       d2;

  // format register; the user must change it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fmt_q <= FMT_DOUBLE;
    else if (element_format_we_i) fmt_q <= element_format_i;
  end

  assign busy_o = 1'b0;

  tetd_unpack u_unpack (
    .clk_i, .rst_ni, .vld_i(start_i), .fmt_i(fmt_q), .raw_i(raw_bits_i),
    .vld_o(v1), .dat_o(d1)
  );
  tetd_lzc u_lzc (
    .clk_i, .rst_ni, .vld_i(v1), .dat_i(d1), .vld_o(v2), .dat_o(d2)
  );
  tetd_pack u_pack (
    .clk_i, .rst_ni, .vld_i(v2), .dat_i(d2), .vld_o(done_o), .val_o(value_bits_o)
  );
endmodule

### sv/tetd_unpack.sv
// tetd_unpack: stage one, selects field layout per format
// depends on tetd_pkg
module tetd_unpack import tetd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  input  logic [1:0]  fmt_i,
  input  logic [63:0] raw_i,
  output logic        vld_o,
  output unpk_t       dat_o
);
  unpk_t dat_d, dat_q;
  logic  vld_q;
  logic [31:0] w;

  always_comb begin
    w = raw_i[31:0];
    if (fmt_i == FMT_BF16) w = {raw_i[15:0], 16'h0000};
    dat_d = '0;
    dat_d.raw = raw_i;
    dat_d.pass = (fmt_i == FMT_DOUBLE);
    if (fmt_i == FMT_HALF) begin
      dat_d.is_half = 1'b1;
      dat_d.sign = raw_i[15];
      dat_d.ex = {3'b000, raw_i[14:10]};
      dat_d.fr = {raw_i[9:0], 13'h0};
      if (raw_i[14:10] == 5'h1F) dat_d.cls = CLS_SPEC;
      else if (raw_i[14:10] != 5'h00) dat_d.cls = CLS_NORM;
      else if (raw_i[9:0] == 10'h0) dat_d.cls = CLS_ZERO;
      else dat_d.cls = CLS_SUB;
    end else begin
      dat_d.sign = w[31];
      dat_d.ex = w[30:23];
      dat_d.fr = w[22:0];
      if (w[30:23] == 8'hFF) dat_d.cls = CLS_SPEC;
      else if (w[30:23] != 8'h00) dat_d.cls = CLS_NORM;
      else if (w[22:0] == 23'h0) dat_d.cls = CLS_ZERO;
      else dat_d.cls = CLS_SUB;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else vld_q <= vld_i;
  end
  always_ff @(posedge clk_i) dat_q <= dat_d;

  assign vld_o = vld_q;
  assign dat_o = dat_q;
endmodule

### sv/tetd_lzc.sv
// tetd_lzc: stage two, leading-zero count of the fraction
// depends on tetd_pkg
module tetd_lzc import tetd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  vld_i,
  input  unpk_t dat_i,
  output logic  vld_o,
  output lzc_t  dat_o
);
  lzc_t dat_d, dat_q;
  logic vld_q;

  always_comb begin
    dat_d.pass = dat_i.pass;
    dat_d.raw = dat_i.raw;
    dat_d.sign = dat_i.sign;
    dat_d.is_half = dat_i.is_half;
    dat_d.cls = dat_i.cls;
    dat_d.ex = dat_i.ex;
    dat_d.fr = dat_i.fr;
    dat_d.lz = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (dat_i.fr[i]) dat_d.lz = 5'(22 - i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else vld_q <= vld_i;
  end
  always_ff @(posedge clk_i) dat_q <= dat_d;

  assign vld_o = vld_q;
  assign dat_o = dat_q;
endmodule

### sv/tetd_pack.sv
// tetd_pack: stage three, normalise and build the binary64 word
// depends on tetd_pkg
module tetd_pack import tetd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  input  lzc_t        dat_i,
  output logic        vld_o,
  output logic [63:0] val_o
);
  logic [63:0] val_d, val_q;
  logic        vld_q;
  logic [22:0] nfr;
  logic [10:0] eb;

  always_comb begin
    nfr = (dat_i.fr << dat_i.lz) << 1;
    // exponent bias: half 1008 normal, single 896
    eb = dat_i.is_half ? 11'(dat_i.ex) + 11'd1008 : 11'(dat_i.ex) + 11'd896;
    val_d = {dat_i.sign, 63'h0};
    case (dat_i.cls)
      CLS_NORM: val_d = {dat_i.sign, eb, dat_i.fr, 29'h0};
      CLS_ZERO: val_d = {dat_i.sign, 63'h0};
      CLS_SUB: begin
        // single: 896 - lz; half: 1008 - lz (p = 9-lz, +999)
        if (dat_i.is_half) val_d = {dat_i.sign, 11'd1008 - 11'(dat_i.lz), nfr, 29'h0};
        else val_d = {dat_i.sign, 11'd896 - 11'(dat_i.lz), nfr, 29'h0};
      end
      CLS_SPEC: begin
        if (dat_i.fr == 23'h0) val_d = {dat_i.sign, 11'h7FF, 52'h0};
        else if (dat_i.is_half) val_d = {dat_i.sign, 11'h7FF, 1'b1, 51'h0};
        else val_d = {dat_i.sign, 11'h7FF, 1'b1, dat_i.fr[21:0], 29'h0};
      end
      default: val_d = '0;
    endcase
    if (dat_i.pass) val_d = dat_i.raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else vld_q <= vld_i;
  end
  always_ff @(posedge clk_i) val_q <= val_d;

  assign vld_o = vld_q;
  assign val_o = val_q;
endmodule

### sim/tensor_element_to_double_top_test.sv
// tensor_element_to_double_top_test: self-checking bench for the element widener
// depends on tetd_pkg and tensor_element_to_double_top
`timescale 1ns / 1ps

module tensor_element_to_double_top_test;
  import tetd_pkg::*;

  localparam int LATENCY = 3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        element_format_we_i = 1'b0;
  logic [1:0]  element_format_i = FMT_DOUBLE;
  logic        start_i = 1'b0;
  logic [63:0] raw_bits_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [63:0] value_bits_o;

  tensor_element_to_double_top u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .element_format_we_i (element_format_we_i),
    .element_format_i    (element_format_i),
    .start_i             (start_i),
    .raw_bits_i          (raw_bits_i),
    .busy_o              (busy_o),
    .done_o              (done_o),
    .value_bits_o        (value_bits_o)
  );

  always #1 clk_i = ~clk_i;

  // words waiting to be sent
  logic [63:0] pending_words[$];
  logic [1:0]  cur_format = FMT_DOUBLE;
  bit          gaps_on = 1'b1;
  bit          hold_off = 1'b0;
  int          errors = 0;
  int          gap_left = 0;

  // index of the highest set bit
  function automatic int msb_pos(logic [22:0] v);
    int p;
    p = 0;
    for (int i = 0; i < 23; i++)
      if (v[i]) p = i;
    return p;
  endfunction

  function automatic logic [63:0] single_to_double(logic [31:0] w);
    logic [63:0] s;
    logic [7:0]  e;
    logic [22:0] f;
    logic [51:0] fr52;
    int          p;
    s = {w[31], 63'd0};
    e = w[30:23];
    f = w[22:0];
    if (e == 8'd0) begin
      if (f == '0) return s;
      p = msb_pos(f);
      // normalise: drop the leading one, left align in the 52-bit fraction
      fr52 = {29'd0, f} << (52 - p);
      return s | (64'(p + 874) << 52) | 64'(fr52);
    end
    if (e == 8'hFF) begin
      if (f == '0) return s | 64'h7FF0_0000_0000_0000;
      return s | 64'h7FF8_0000_0000_0000 | (64'(f) << 29);
    end
    return s | (64'(e + 896) << 52) | (64'(f) << 29);
  endfunction

  function automatic logic [63:0] half_to_double(logic [15:0] h);
    logic [63:0] s;
    logic [4:0]  e;
    logic [9:0]  f;
    logic [51:0] fr52;
    int          p;
    s = {h[15], 63'd0};
    e = h[14:10];
    f = h[9:0];
    if (e == 5'd0) begin
      if (f == '0) return s;
      p = msb_pos({13'd0, f});
      fr52 = {42'd0, f} << (52 - p);
      return s | (64'(p + 999) << 52) | 64'(fr52);
    end
    // any half nan collapses to the canonical quiet nan
    if (e == 5'h1F) return s | (f == '0 ? 64'h7FF0_0000_0000_0000 : 64'h7FF8_0000_0000_0000);
    return s | (64'(e + 1008) << 52) | (64'(f) << 42);
  endfunction

  function automatic logic [63:0] widen_element(logic [1:0] fmt, logic [63:0] raw);
    case (fmt)
      FMT_DOUBLE: return raw;
      FMT_SINGLE: return single_to_double(raw[31:0]);
      FMT_HALF:   return half_to_double(raw[15:0]);
      default:    return single_to_double({raw[15:0], 16'd0});
    endcase
  endfunction

  // driver: one word per accepted start, random gaps unless switched off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i  <= 1'b0;
      end else if (pending_words.size() != 0 && !hold_off) begin
        if (gaps_on && $urandom_range(0, 9) == 0) begin
          gap_left <= int'($urandom_range(1, 13)) - 1;
          start_i  <= 1'b0;
        end else begin
          start_i    <= 1'b1;
          raw_bits_i <= pending_words.pop_front();
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // expectations are recorded at acceptance, using the word actually on the port
  logic [63:0] accepted_doubles[$];
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o)
      accepted_doubles = {accepted_doubles, widen_element(cur_format, raw_bits_i)};
  end

  // monitor: each strobed result against the oldest accepted word
  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni && done_o) begin
      if (accepted_doubles.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, value_bits_o);
        errors++;
      end else begin
        want = accepted_doubles.pop_front();
        if (value_bits_o !== want) begin
          $display("%0t: value_bits mismatch, expected %h, actual %h", $time, want,
                   value_bits_o);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() != 0 || start_i || accepted_doubles.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic set_format(logic [1:0] fmt);
    wait_drained();
    @(negedge clk_i);
    element_format_we_i <= 1'b1;
    element_format_i    <= fmt;
    cur_format          <= fmt;
    @(negedge clk_i);
    element_format_we_i <= 1'b0;
    element_format_i    <= 2'($urandom_range(0, 3));
  endtask

  // random word shaped for the format: specials, subnormals and ordinary values
  function automatic logic [63:0] random_word(logic [1:0] fmt);
    logic [63:0] w;
    int          pick;
    w = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    case (fmt)
      FMT_SINGLE: begin
        if (pick < 2) w[30:23] = 8'h00;
        else if (pick < 4) w[30:23] = 8'hFF;
        if (pick == 1 || pick == 3) w[22:0] = pick == 3 ? '0 : 23'(1) << $urandom_range(0, 22);
      end
      FMT_HALF, FMT_BF16: begin
        if (fmt == FMT_HALF) begin
          if (pick < 2) w[14:10] = 5'h00;
          else if (pick < 4) w[14:10] = 5'h1F;
          if (pick == 1 || pick == 3) w[9:0] = pick == 3 ? '0 : 10'(1) << $urandom_range(0, 9);
        end else begin
          if (pick < 2) w[14:7] = 8'h00;
          else if (pick < 4) w[14:7] = 8'hFF;
          if (pick == 1 || pick == 3) w[6:0] = pick == 3 ? '0 : 7'(1) << $urandom_range(0, 6);
        end
      end
      default: begin
        if (pick < 2) w[62:52] = '0;
        else if (pick < 4) w[62:52] = '1;
      end
    endcase
    return w;
  endfunction

  localparam logic [1:0] FORMAT_ORDER[8] = '{FMT_SINGLE, FMT_HALF, FMT_BF16, FMT_DOUBLE,
                                             FMT_HALF, FMT_SINGLE, FMT_BF16, FMT_DOUBLE};

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and special cases in each format, double first (reset value)
    for (int f = 0; f < 4; f++) begin
      if (f != 0) set_format(2'(f));
      pending_words = {pending_words, 64'h0};
      pending_words = {pending_words, 64'hFFFF_FFFF_FFFF_FFFF};
      pending_words = {pending_words, 64'hFFFF_0000_0000_8000};  // negative zero, junk above
      pending_words = {pending_words, 64'h0000_0000_0000_0001};  // smallest subnormal
      pending_words = {pending_words, 64'h0000_0000_8000_03FF};  // largest half subnormal
      pending_words = {pending_words, 64'h1234_5678_7C00_7F80};  // infinities
      pending_words = {pending_words, 64'h0000_0000_FC01_7FC1};  // nans with payloads
      pending_words = {pending_words, 64'h7FF0_0000_0040_0001};  // double signalling nan
      pending_words = {pending_words, 64'h3FF0_0000_3F80_3C00};  // ones
    end

    // random phases through every format, pausing once for a full drain
    for (int ph = 0; ph < 8; ph++) begin
      set_format(FORMAT_ORDER[ph]);
      if (ph == 7) gaps_on = 1'b0;
      for (int i = 0; i < 88; i++)
        pending_words = {pending_words, random_word(FORMAT_ORDER[ph])};
      if (ph == 3) begin
        while (pending_words.size() > 40) @(posedge clk_i);
        hold_off = 1'b1;
        while (accepted_doubles.size() != 0 || start_i) @(posedge clk_i);
        hold_off = 1'b0;
      end
    end

    wait_drained();
    repeat (LATENCY * 4) @(posedge clk_i);
    if (errors == 0)
      $display("tensor_element_to_double_top test passed");
    else
      $display("tensor_element_to_double_top test failed");
    $finish;
  end

  initial begin
    #200000;
    $display("tensor_element_to_double_top test failed");
    $finish;
  end
endmodule

### tensor_element_to_double_top.f
sv/tetd_pkg.sv
sv/tetd_unpack.sv
sv/tetd_lzc.sv
sv/tetd_pack.sv
sv/tensor_element_to_double_top.sv
sim/tensor_element_to_double_top_test.sv
